### src/odo_pkg.sv
package odo_pkg;

  // Default build parameters
  localparam int unsigned COUNT_BITS_DEF   = 22;
  localparam int unsigned POS_BITS_DEF     = 32;
  localparam int unsigned ANGLE_BITS_DEF   = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Register widths and the configuration port
  localparam int unsigned DPP_W  = 16;
  localparam int unsigned WB_W   = 12;
  localparam int unsigned SPAN_W = 23;
  localparam int unsigned CFG_AW = 2;

  // Fixed output formats
  localparam int unsigned STEP_W = 26;
  localparam int unsigned VEC_W  = 38;

  typedef enum logic [CFG_AW-1:0] {
    REG_DPP        = 2'd0,
    REG_WHEEL_BASE = 2'd1,
    REG_SPAN       = 2'd2
  } odo_reg_e;

  localparam logic [DPP_W-1:0]  DPP_RST  = 16'd36208;
  localparam logic [WB_W-1:0]   WB_RST   = 12'd570;
  localparam logic [SPAN_W-1:0] SPAN_RST = 23'd3932160;

  // round(2^39/pi) and the inverse CORDIC gain in Q30
  localparam logic [37:0] TURN_K   = 38'd174992710548;
  localparam logic [29:0] GAIN_INV = 30'd652032874;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MOD,
    B_MUL,
    B_DSTART,
    B_DIV,
    B_TURN,
    B_HEAD,
    B_ROT,
    B_FIN
  } odo_state_e;

  // Arctangent of 2^-i in 32-bit turns
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Clamp to the signed step range
  function automatic logic signed [STEP_W-1:0] sat_step(input logic signed [63:0] v);
    logic signed [STEP_W-1:0] r;
    if (v > 64'sd33554431) r = 26'sh1FFFFFF;
    else if (v < -64'sd33554432) r = -26'sd33554432;
    else r = v[STEP_W-1:0];
    return r;
  endfunction

endpackage

### src/odo_div.sv
module odo_div import odo_pkg::*; #(
  parameter int unsigned NW = 23,
  parameter int unsigned DW = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(NW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, den_q;
  logic [DW:0]   trial, diff;
  logic          ge;

  // One restoring step: bring in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + CW'(1);
      done_q <= (cnt_q == CW'(NW-1));
      if (cnt_q == CW'(NW-1)) begin
        busy_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

### src/odo_queue.sv
module odo_queue import odo_pkg::*; #(
  parameter int unsigned W = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  output logic         pop_valid_o,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o,
  output logic [1:0]   level_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   level_q;
  logic         do_push, do_pop;

  assign full_o      = (level_q == 2'd2);
  assign pop_valid_o = (level_q != 2'd0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;
  assign pop_data_o  = mem_q[rd_q];
  assign level_o     = level_q;

  // Advance pointers and level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      level_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      level_q <= level_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### src/odo_front.sv
module odo_front import odo_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [COUNT_BITS-1:0]       left_count_i,
  input  logic [COUNT_BITS-1:0]       right_count_i,
  input  logic [COUNT_BITS:0]         span_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output logic [2*(COUNT_BITS+2)-1:0] push_data_o
);

  localparam int unsigned DW = COUNT_BITS + 2;

  logic signed [COUNT_BITS:0] last_l_q, last_r_q;
  logic signed [DW-1:0]       s_e, half, c_l, c_r, sl, sr, d_l, d_r;

  // Center each count around half the span and take the raw change
  always_comb begin
    s_e  = signed'({1'b0, span_i});
    half = (s_e - 1) >>> 1;
    c_l  = signed'({2'b00, left_count_i});
    c_r  = signed'({2'b00, right_count_i});
    sl   = (c_l > half) ? c_l - s_e : c_l;
    sr   = (c_r > half) ? c_r - s_e : c_r;
    d_l  = sl - DW'(last_l_q);
    d_r  = sr - DW'(last_r_q);
  end

  assign in_ready_o  = !q_full_i;
  assign push_o      = in_valid_i && in_ready_o;
  assign push_data_o = {d_l, d_r};

  // Hold the previous centered counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q <= '0;
      last_r_q <= '0;
    end else if (push_o) begin
      last_l_q <= sl[COUNT_BITS:0];
      last_r_q <= sr[COUNT_BITS:0];
    end
  end

endmodule

### src/odo_back.sv
module odo_back import odo_pkg::*; #(
  parameter int unsigned COUNT_BITS   = COUNT_BITS_DEF,
  parameter int unsigned POS_BITS     = POS_BITS_DEF,
  parameter int unsigned ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  logic [2*(COUNT_BITS+2)-1:0] q_data_i,
  input  logic [DPP_W-1:0]            dpp_i,
  input  logic [WB_W-1:0]             wb_i,
  input  logic [COUNT_BITS:0]         span_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          pose_x_o,
  output logic signed [31:0]          pose_y_o,
  output logic signed [15:0]          pose_heading_o,
  output logic signed [STEP_W-1:0]    step_x_o,
  output logic signed [STEP_W-1:0]    step_y_o,
  output logic signed [15:0]          step_turn_o
);

  localparam int unsigned DW  = COUNT_BITS + 2;
  localparam int unsigned MW  = COUNT_BITS + 1;
  localparam int unsigned NW  = COUNT_BITS + 17;
  localparam int unsigned PW  = COUNT_BITS + 19;
  localparam int unsigned PXW = (POS_BITS > 32) ? POS_BITS : 32;
  localparam int unsigned HXW = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
  localparam int unsigned SMW = ((POS_BITS > STEP_W) ? POS_BITS : STEP_W) + 1;
  localparam int unsigned ICW = $clog2(CORDIC_STEPS);
  localparam int unsigned SH  = 56 - ANGLE_BITS;
  localparam logic signed [SMW-1:0] PMAX = SMW'((longint'(1) <<< (POS_BITS-1)) - 1);
  localparam logic signed [SMW-1:0] PMIN = -PMAX - 1;

  // Fold a remainder into the symmetric range around zero
  function automatic logic signed [DW-1:0] wrap_rem(input logic [MW-1:0] r, input logic neg,
                                                   input logic [MW-1:0] s);
    logic signed [DW-1:0] rs, ss, m, half;
    rs   = signed'(DW'(r));
    ss   = signed'(DW'(s));
    m    = (neg && (r != '0)) ? ss - rs : rs;
    half = (ss - 1) >>> 1;
    return (m > half) ? m - ss : m;
  endfunction

  odo_state_e state_q, state_d;

  logic                  out_valid_q, out_valid_d;
  logic signed [POS_BITS-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [ANGLE_BITS-1:0] acc_head_q, acc_head_d;
  logic [1:0]            tcnt_q, tcnt_d;
  logic [ICW-1:0]        icnt_q, icnt_d;

  logic signed [DW-1:0]  dl_q, dl_d, dr_q, dr_d;
  logic                  negl_q, negl_d, negr_q, negr_d, tneg_q, tneg_d;
  logic signed [PW-1:0]  fn_q, fn_d, tn_q, tn_d;
  logic signed [STEP_W-1:0] fwd_q, fwd_d;
  logic [55:0]           trad_q, trad_d, tacc_q, tacc_d;
  logic [ANGLE_BITS-1:0] turn_q, turn_d, head_q, head_d;
  logic signed [VEC_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [31:0]    z_q, z_d;

  logic signed [31:0]    pose_x_q, pose_x_d, pose_y_q, pose_y_d;
  logic [15:0]           pose_head_q, pose_head_d, step_turn_q, step_turn_d;
  logic signed [STEP_W-1:0] step_x_q, step_x_d, step_y_q, step_y_d;

  // Datapath nets
  logic signed [DW-1:0]  dl_in, dr_in, sa, sb;
  logic [MW-1:0]         mag_l, mag_r, rem_l, rem_r;
  logic                  mod_start, mod_done, div_start, div_done;
  logic [NW-1:0]         div_num, div_quot;
  logic [WB_W-1:0]       wb_eff;
  logic signed [16:0]    dpp_s;
  logic [PW-1:0]         abs_fn, abs_tn;
  logic [63:0]           q64;
  logic signed [63:0]    fv;
  logic signed [56:0]    xp;
  logic [13:0]           chunk;
  logic [51:0]           pp;
  logic [55:0]           tsum;
  logic [ANGLE_BITS-1:0] turn_c, head_c;
  logic signed [31:0]    zc, at;
  logic signed [VEC_W-1:0] xs, ys, xr, yr;
  logic signed [STEP_W-1:0] stx, sty;
  logic signed [SMW-1:0] sum_x, sum_y;
  logic signed [PXW-1:0] px_ext, py_ext;
  logic [HXW-1:0]        h_ext, t_ext;

  assign dl_in     = signed'(q_data_i[2*DW-1:DW]);
  assign dr_in     = signed'(q_data_i[DW-1:0]);
  assign q_ready_o = (state_q == B_IDLE);
  assign mod_start = q_ready_o && q_valid_i;
  assign div_start = (state_q == B_DSTART);
  assign wb_eff    = (wb_i == '0) ? WB_W'(1) : wb_i;
  assign dpp_s     = signed'({1'b0, dpp_i});

  always_comb begin
    mag_l   = dl_in[DW-1] ? MW'(-dl_in) : MW'(dl_in);
    mag_r   = dr_in[DW-1] ? MW'(-dr_in) : MW'(dr_in);
    abs_fn  = fn_q[PW-1] ? PW'(-fn_q) : PW'(fn_q);
    abs_tn  = tn_q[PW-1] ? PW'(-tn_q) : PW'(tn_q);
    div_num = NW'(abs_tn) + NW'(wb_i >> 1);
  end

  // Span modulo for both wheels
  odo_div #(.NW(MW), .DW(MW)) u_mod_l (
    .clk_i, .rst_ni, .start_i(mod_start), .num_i(mag_l), .den_i(span_i),
    .done_o(mod_done), .quot_o(), .rem_o(rem_l)
  );

  odo_div #(.NW(MW), .DW(MW)) u_mod_r (
    .clk_i, .rst_ni, .start_i(mod_start), .num_i(mag_r), .den_i(span_i),
    .done_o(), .quot_o(), .rem_o(rem_r)
  );

  // Rounded divide by the wheel base
  odo_div #(.NW(NW), .DW(WB_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(wb_eff),
    .done_o(div_done), .quot_o(div_quot), .rem_o()
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    acc_head_d  = acc_head_q;
    tcnt_d      = tcnt_q;
    icnt_d      = icnt_q;
    dl_d = dl_q;  dr_d = dr_q;
    negl_d = negl_q;  negr_d = negr_q;  tneg_d = tneg_q;
    fn_d = fn_q;  tn_d = tn_q;  fwd_d = fwd_q;
    trad_d = trad_q;  tacc_d = tacc_q;
    turn_d = turn_q;  head_d = head_q;
    x_d = x_q;  y_d = y_q;  z_d = z_q;
    pose_x_d = pose_x_q;  pose_y_d = pose_y_q;  pose_head_d = pose_head_q;
    step_x_d = step_x_q;  step_y_d = step_y_q;  step_turn_d = step_turn_q;

    sa     = dr_q - dl_q;
    sb     = dr_q + dl_q;
    q64    = (64'(abs_fn) + 64'd4096) >> 13;
    fv     = fn_q[PW-1] ? -signed'(q64) : signed'(q64);
    xp     = fwd_q * signed'({1'b0, GAIN_INV});
    chunk  = trad_q[tcnt_q*14 +: 14];
    pp     = chunk * TURN_K;
    tsum   = tacc_q + (56'(1) << (SH-1));
    turn_c = tsum[55:SH];
    head_c = acc_head_q + turn_c;
    zc     = signed'(32'(head_c) << (32-ANGLE_BITS));
    at     = signed'(atan_lut(5'(icnt_q)));
    xs     = x_q >>> icnt_q;
    ys     = y_q >>> icnt_q;
    xr     = (x_q + 128) >>> 8;
    yr     = (y_q + 128) >>> 8;
    stx    = sat_step(64'(xr));
    sty    = sat_step(64'(yr));
    sum_x  = SMW'(acc_x_q) + SMW'(stx);
    sum_y  = SMW'(acc_y_q) + SMW'(sty);
    px_ext = '0;
    py_ext = '0;
    h_ext  = HXW'(head_q);
    t_ext  = HXW'(turn_q);

    // Drop the result once taken
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          negl_d  = dl_in[DW-1];
          negr_d  = dr_in[DW-1];
          state_d = B_MOD;
        end
      end
      B_MOD: begin
        if (mod_done) begin
          dl_d    = wrap_rem(rem_l, negl_q, span_i);
          dr_d    = wrap_rem(rem_r, negr_q, span_i);
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        // Left travel is negated, so difference drives forward and sum drives turn
        fn_d    = sa * dpp_s;
        tn_d    = sb * dpp_s;
        state_d = B_DSTART;
      end
      B_DSTART: begin
        fwd_d   = sat_step(fv);
        tneg_d  = tn_q[PW-1];
        state_d = B_DIV;
      end
      B_DIV: begin
        x_d = VEC_W'(xp >>> 22);
        if (div_done) begin
          trad_d  = tneg_q ? -(56'(div_quot)) : 56'(div_quot);
          tacc_d  = '0;
          tcnt_d  = '0;
          state_d = B_TURN;
        end
      end
      B_TURN: begin
        // Radians to binary angle, 14 bits of the multiplicand per cycle
        tacc_d = tacc_q + (56'(pp) << (14*tcnt_q));
        tcnt_d = tcnt_q + 2'd1;
        if (tcnt_q == 2'd3) state_d = B_HEAD;
      end
      B_HEAD: begin
        turn_d = turn_c;
        head_d = head_c;
        y_d    = '0;
        icnt_d = '0;
        if (zc > 32'sh40000000 || zc < -32'sh40000000) begin
          x_d = -x_q;
          z_d = zc + 32'sh80000000;
        end else begin
          z_d = zc;
        end
        state_d = B_ROT;
      end
      B_ROT: begin
        if (!z_q[31]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - at;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + at;
        end
        icnt_d = icnt_q + ICW'(1);
        if (icnt_q == ICW'(CORDIC_STEPS-1)) state_d = B_FIN;
      end
      B_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          if (sum_x > PMAX) acc_x_d = POS_BITS'(PMAX);
          else if (sum_x < PMIN) acc_x_d = POS_BITS'(PMIN);
          else acc_x_d = POS_BITS'(sum_x);
          if (sum_y > PMAX) acc_y_d = POS_BITS'(PMAX);
          else if (sum_y < PMIN) acc_y_d = POS_BITS'(PMIN);
          else acc_y_d = POS_BITS'(sum_y);
          acc_head_d  = head_q;
          px_ext      = PXW'(acc_x_d);
          py_ext      = PXW'(acc_y_d);
          pose_x_d    = px_ext[31:0];
          pose_y_d    = py_ext[31:0];
          pose_head_d = h_ext[15:0];
          step_x_d    = stx;
          step_y_d    = sty;
          step_turn_d = t_ext[15:0];
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_head_q  <= '0;
      tcnt_q      <= '0;
      icnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      acc_head_q  <= acc_head_d;
      tcnt_q      <= tcnt_d;
      icnt_q      <= icnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q <= dl_d;  dr_q <= dr_d;
    negl_q <= negl_d;  negr_q <= negr_d;  tneg_q <= tneg_d;
    fn_q <= fn_d;  tn_q <= tn_d;  fwd_q <= fwd_d;
    trad_q <= trad_d;  tacc_q <= tacc_d;
    turn_q <= turn_d;  head_q <= head_d;
    x_q <= x_d;  y_q <= y_d;  z_q <= z_d;
    pose_x_q <= pose_x_d;  pose_y_q <= pose_y_d;  pose_head_q <= pose_head_d;
    step_x_q <= step_x_d;  step_y_q <= step_y_d;  step_turn_q <= step_turn_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pose_x_o       = pose_x_q;
  assign pose_y_o       = pose_y_q;
  assign pose_heading_o = signed'(pose_head_q);
  assign step_x_o       = step_x_q;
  assign step_y_o       = step_y_q;
  assign step_turn_o    = signed'(step_turn_q);

endmodule

### src/differential_drive_odometry.sv
// Differential-drive wheel odometry. Each transfer on the input carries the raw left and
// right encoder counters; each produces one result with the saturating pose (x, y in
// 1/16 mm, heading as a binary angle) and this sample's displacement and turn. A sample
// takes the bit-serial span modulo, then the bit-serial divide by the wheel base, then the
// CORDIC rotation, which run one after the other; a two-entry queue in front lets up to
// two further samples be taken while one is in work. Configuration writes take effect at
// once and belong between samples.
module differential_drive_odometry import odo_pkg::*; #(
  parameter int unsigned COUNT_BITS   = COUNT_BITS_DEF,
  parameter int unsigned POS_BITS     = POS_BITS_DEF,
  parameter int unsigned ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_AW-1:0]        cfg_addr_i,
  input  logic [SPAN_W-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [COUNT_BITS-1:0]    left_count_i,
  input  logic [COUNT_BITS-1:0]    right_count_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [31:0]       pose_x_o,
  output logic signed [31:0]       pose_y_o,
  output logic signed [15:0]       pose_heading_o,
  output logic signed [STEP_W-1:0] step_x_o,
  output logic signed [STEP_W-1:0] step_y_o,
  output logic signed [15:0]       step_turn_o
);

  localparam int unsigned QW   = 2 * (COUNT_BITS + 2);
  localparam int unsigned CMPW = (COUNT_BITS + 1 > SPAN_W) ? COUNT_BITS + 1 : SPAN_W;

  logic [DPP_W-1:0]  dpp_q;
  logic [WB_W-1:0]   wb_q;
  logic [SPAN_W-1:0] span_q;
  logic [CMPW-1:0]   span_ext, span_top, span_clip;
  logic [COUNT_BITS:0] span_eff;

  logic          q_full, q_push, q_valid, q_ready, q_pop;
  logic [QW-1:0] q_wdata, q_rdata;
  logic [1:0]    q_level;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpp_q  <= DPP_RST;
      wb_q   <= WB_RST;
      span_q <= SPAN_RST;
    end else if (cfg_we_i) begin
      case (odo_reg_e'(cfg_addr_i))
        REG_DPP:        dpp_q  <= cfg_wdata_i[DPP_W-1:0];
        REG_WHEEL_BASE: wb_q   <= cfg_wdata_i[WB_W-1:0];
        REG_SPAN:       span_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the span to what the counter width allows
  always_comb begin
    span_ext  = CMPW'(span_q);
    span_top  = CMPW'(1) << COUNT_BITS;
    span_clip = (span_ext < CMPW'(2)) ? CMPW'(2) :
                ((span_ext > span_top) ? span_top : span_ext);
    span_eff  = span_clip[COUNT_BITS:0];
  end

  odo_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .left_count_i, .right_count_i,
    .span_i(span_eff), .q_full_i(q_full), .push_o(q_push), .push_data_o(q_wdata)
  );

  odo_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .push_data_i(q_wdata), .full_o(q_full),
    .pop_valid_o(q_valid), .pop_i(q_ready), .pop_data_o(q_rdata), .level_o(q_level)
  );

  odo_back #(
    .COUNT_BITS(COUNT_BITS), .POS_BITS(POS_BITS),
    .ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_rdata),
    .dpp_i(dpp_q), .wb_i(wb_q), .span_i(span_eff),
    .out_valid_o, .out_ready_i,
    .pose_x_o, .pose_y_o, .pose_heading_o, .step_x_o, .step_y_o, .step_turn_o
  );

  assign q_pop = q_valid && q_ready;

  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= 2'd2)
    else $error("queue level beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !q_pop) |=> (q_level == $past(q_level) + 2'd1))
    else $error("accepted sample not queued");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_level != 2'd0))
    else $error("pop from empty queue");

endmodule
